### hw/rtl/crfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crfr_pkg;

  localparam int FRAME_BYTES  = 31;
  localparam int LEGACY_BYTES = 29;

  localparam int POS_W    = 6;
  localparam int IDLE_W   = 8;
  localparam int LOCK_W   = 6;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [POS_W-1:0]  POS_MAX  = '1;
  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

  localparam logic [7:0]        HEADER_RST  = 8'hA5;
  localparam logic [15:0]       POLY_RST    = 16'h8408;
  localparam logic [15:0]       START_RST   = 16'hFFFF;
  localparam logic [LOCK_W-1:0] THRESH_RST  = 6'd50;
  localparam logic [IDLE_W-1:0] TIMEOUT_RST = 8'd100;

  typedef enum logic [2:0] {
    REG_HEADER  = 3'd0,
    REG_POLY    = 3'd1,
    REG_START   = 3'd2,
    REG_THRESH  = 3'd3,
    REG_TIMEOUT = 3'd4
  } reg_idx_e;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_BAD_HEADER = 2'd0,
    ST_CHECK_FAIL = 2'd1,
    ST_NEW_OK     = 2'd2,
    ST_LEGACY_OK  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]        header_value;
    logic [15:0]       crc_polynomial;
    logic [15:0]       crc_start;
    logic [LOCK_W-1:0] lock_threshold;
    logic [IDLE_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       pitch_bits;
    logic [31:0]       yaw_bits;
    logic [31:0]       yaw_offset_bits;
    logic [31:0]       pitch_offset_bits;
    logic [31:0]       range_bits;
    logic              fire_advice;
    logic [31:0]       lateral_speed_bits;
    logic              tracking;
    logic [LOCK_W-1:0] lock_count;
  } result_t;

  // reflected byte-wise CRC16 update, table entry built on the fly
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = {8'h00, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return (crc >> 8) ^ c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/crfr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface crfr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output req_type, output data_byte, output frame_end,
                  input ready);
  modport sink (input valid, input req_type, input data_byte, input frame_end,
                output ready);
endinterface

`default_nettype wire

### hw/rtl/crfr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface crfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] pitch_bits;
  logic [31:0] yaw_bits;
  logic [31:0] yaw_offset_bits;
  logic [31:0] pitch_offset_bits;
  logic [31:0] range_bits;
  logic        fire_advice;
  logic [31:0] lateral_speed_bits;
  logic        tracking;
  logic [5:0]  lock_count;

  modport source (output valid, output status, output pitch_bits, output yaw_bits,
                  output yaw_offset_bits, output pitch_offset_bits, output range_bits,
                  output fire_advice, output lateral_speed_bits, output tracking,
                  output lock_count, input ready);
  modport sink (input valid, input status, input pitch_bits, input yaw_bits,
                input yaw_offset_bits, input pitch_offset_bits, input range_bits,
                input fire_advice, input lateral_speed_bits, input tracking,
                input lock_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/crfr_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module crfr_apb_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [crfr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [crfr_pkg::DATA_W-1:0] pwdata,
  output logic      [crfr_pkg::DATA_W-1:0] prdata,
  output logic                              pready,
  output crfr_pkg::cfg_t                    cfg_o
);
  import crfr_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_HEADER:  cfg_d.header_value   = pwdata[7:0];
        REG_POLY:    cfg_d.crc_polynomial = pwdata[15:0];
        REG_START:   cfg_d.crc_start      = pwdata[15:0];
        REG_THRESH:  cfg_d.lock_threshold = pwdata[LOCK_W-1:0];
        REG_TIMEOUT: cfg_d.timeout_ticks  = pwdata[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_HEADER:  prdata = DATA_W'(cfg_q.header_value);
      REG_POLY:    prdata = DATA_W'(cfg_q.crc_polynomial);
      REG_START:   prdata = DATA_W'(cfg_q.crc_start);
      REG_THRESH:  prdata = DATA_W'(cfg_q.lock_threshold);
      REG_TIMEOUT: prdata = DATA_W'(cfg_q.timeout_ticks);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_value   <= HEADER_RST;
      cfg_q.crc_polynomial <= POLY_RST;
      cfg_q.crc_start      <= START_RST;
      cfg_q.lock_threshold <= THRESH_RST;
      cfg_q.timeout_ticks  <= TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/crfr_frame_core.sv
`timescale 1ns / 1ps
`default_nettype none

module crfr_frame_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire crfr_pkg::cfg_t  cfg_i,
  input  wire logic            item_valid_i,
  input  wire crfr_pkg::item_t item_i,
  output logic                 take_o,
  output logic                 res_valid_o,
  output crfr_pkg::result_t    res_o,
  input  wire logic            res_ready_i
);
  import crfr_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [15:0]       crc_q, crc_d;
  logic [15:0]       leg_snap_q, leg_snap_d;
  logic [15:0]       new_snap_q, new_snap_d;
  logic [7:0]        store_q [FRAME_BYTES];
  logic [7:0]        store_d [FRAME_BYTES];
  logic [LOCK_W-1:0] lock_q, lock_d;
  logic              track_q, track_d;
  logic              seen_q, seen_d;
  logic [IDLE_W-1:0] idle_q, idle_d, idle_inc;
  logic              res_valid_q;
  result_t           res_q, res_d;

  logic              is_byte, is_last, produces;
  logic [15:0]       cur;
  logic              is_new, is_legacy, frame_ok, range_pos;
  status_e           status;
  logic [31:0]       range_w;

  assign is_byte  = (req_e'(item_i.req_type) == REQ_BYTE);
  assign is_last  = is_byte && item_i.frame_end;
  assign produces = is_last;
  assign take_o   = item_valid_i && (!produces || !res_valid_q || res_ready_i);
  assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 1'b1;

  always_comb begin
    cur        = (pos_q == '0) ? cfg_i.crc_start : crc_q;
    leg_snap_d = (pos_q == POS_W'(LEGACY_BYTES - 2)) ? cur : leg_snap_q;
    new_snap_d = (pos_q == POS_W'(FRAME_BYTES - 2)) ? cur : new_snap_q;
    store_d    = store_q;
    crc_d      = cur;
    if (pos_q < POS_W'(FRAME_BYTES)) begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
        if (pos_q == POS_W'(k)) store_d[k] = item_i.data_byte;
      end
      crc_d = crc_byte(cur, item_i.data_byte, cfg_i.crc_polynomial);
    end
    if (item_i.frame_end) pos_d = '0;
    else pos_d = (pos_q == POS_MAX) ? POS_MAX : pos_q + 1'b1;
  end

  always_comb begin
    is_new    = (pos_q >= POS_W'(FRAME_BYTES - 1)) &&
                (new_snap_d == {store_d[FRAME_BYTES-1], store_d[FRAME_BYTES-2]});
    is_legacy = !is_new && (pos_q >= POS_W'(LEGACY_BYTES - 1)) &&
                (leg_snap_d == {store_d[LEGACY_BYTES-1], store_d[LEGACY_BYTES-2]});
    if (store_d[0] != cfg_i.header_value) status = ST_BAD_HEADER;
    else if (is_new)                      status = ST_NEW_OK;
    else if (is_legacy)                   status = ST_LEGACY_OK;
    else                                  status = ST_CHECK_FAIL;
    frame_ok  = (status == ST_NEW_OK) || (status == ST_LEGACY_OK);
    range_w   = {store_d[20], store_d[19], store_d[18], store_d[17]};
    range_pos = !range_w[31] && (range_w[30:0] != '0) && (range_w[30:0] <= 31'h7F800000);
  end

  always_comb begin
    lock_d  = lock_q;
    track_d = track_q;
    seen_d  = seen_q;
    idle_d  = idle_q;
    if (!is_byte) begin
      idle_d = idle_inc;
      if (seen_q && (idle_inc > cfg_i.timeout_ticks)) begin
        lock_d  = '0;
        track_d = 1'b0;
      end
    end else if (is_last) begin
      if (frame_ok) begin
        seen_d = 1'b1;
        idle_d = '0;
        if (!range_pos) lock_d = '0;
        else if (lock_q < cfg_i.lock_threshold) lock_d = lock_q + 1'b1;
        track_d = (lock_d >= cfg_i.lock_threshold);
      end else if (seen_q && (idle_q > cfg_i.timeout_ticks)) begin
        lock_d  = '0;
        track_d = 1'b0;
      end
    end
  end

  always_comb begin
    res_d        = '0;
    res_d.status = status;
    if (frame_ok) begin
      res_d.pitch_bits        = {store_d[4], store_d[3], store_d[2], store_d[1]};
      res_d.yaw_bits          = {store_d[8], store_d[7], store_d[6], store_d[5]};
      res_d.yaw_offset_bits   = {store_d[12], store_d[11], store_d[10], store_d[9]};
      res_d.pitch_offset_bits = {store_d[16], store_d[15], store_d[14], store_d[13]};
      res_d.range_bits        = range_w;
      res_d.fire_advice       = store_d[21][0];
      if (status == ST_NEW_OK) begin
        res_d.lateral_speed_bits = {store_d[28], store_d[27], store_d[26], store_d[25]};
      end
    end
    res_d.tracking   = track_d;
    res_d.lock_count = lock_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= '0;
      leg_snap_q  <= '0;
      new_snap_q  <= '0;
      lock_q      <= '0;
      track_q     <= 1'b0;
      seen_q      <= 1'b0;
      idle_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        if (is_byte) begin
          pos_q      <= pos_d;
          crc_q      <= crc_d;
          leg_snap_q <= leg_snap_d;
          new_snap_q <= new_snap_d;
        end
        lock_q  <= lock_d;
        track_q <= track_d;
        seen_q  <= seen_d;
        idle_q  <= idle_d;
      end
      if (take_o && produces) res_valid_q <= 1'b1;
      else if (res_ready_i)   res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && is_byte) store_q <= store_d;
    if (take_o && produces) res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### hw/rtl/crc_checked_frame_receiver_unit.sv
// Frame receiver with CRC16 check and target lock tracking.
// in_i carries one beat per received byte (req_type 0, frame_end marks the
// last byte of a frame) or per timer tick (req_type 1). out_o carries
// one result beat for every byte beat with frame_end set, none otherwise.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8, 12
// and 16; pready is always high.
// A result passes through the input register and then the result register;
// the core takes a frame-end beat only once any pending result has been
// taken. Throughput: one beat per cycle while out_o takes results; the byte
// CRC update and frame check are combinational.
// Reset clears the byte position, lock counter, tracking, idle tick count
// and the valid flags of both beat registers, and loads the register
// defaults; stored frame bytes are not cleared.
// When the receiver on out_o stalls, the result holds. Ticks and bytes that
// do not end a frame keep flowing; a frame-end byte waits in the input
// register and in_i.ready drops until the pending result is taken.
`timescale 1ns / 1ps
`default_nettype none

module crc_checked_frame_receiver_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  crfr_in_if.sink                           in_i,
  crfr_out_if.source                        out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [crfr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [crfr_pkg::DATA_W-1:0] pwdata,
  output logic      [crfr_pkg::DATA_W-1:0] prdata,
  output logic                              pready
);
  import crfr_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  logic    take;
  logic    res_valid;
  result_t res;
  logic    accept;

  crfr_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_i.ready = !in_valid_q || take;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.req_type  <= in_i.req_type;
      item_q.data_byte <= in_i.data_byte;
      item_q.frame_end <= in_i.frame_end;
    end
  end

  crfr_frame_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (in_valid_q),
    .item_i       (item_q),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (out_o.ready)
  );

  assign out_o.valid              = res_valid;
  assign out_o.status             = res.status;
  assign out_o.pitch_bits         = res.pitch_bits;
  assign out_o.yaw_bits           = res.yaw_bits;
  assign out_o.yaw_offset_bits    = res.yaw_offset_bits;
  assign out_o.pitch_offset_bits  = res.pitch_offset_bits;
  assign out_o.range_bits         = res.range_bits;
  assign out_o.fire_advice        = res.fire_advice;
  assign out_o.lateral_speed_bits = res.lateral_speed_bits;
  assign out_o.tracking           = res.tracking;
  assign out_o.lock_count         = res.lock_count;

endmodule

`default_nettype wire
